FILE: rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_CMP = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIVZERO  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} item_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               is_equal;
		logic [1:0]         status;
	} result_t;

	typedef enum logic [1:0] {
		RK_ZERO,
		RK_DIVZERO,
		RK_CMP,
		RK_FINAL
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      mul_en;
		logic      form;
		logic      gcd_step;
		logic      div_init;
		logic      div_sel;
		logic      div_step;
		logic      emit;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic bad_mode;
		logic den_zero;
		logic div_zero;
		logic is_cmp;
		logic num_zero;
		logic gcd_done;
	} sts_t;

endpackage

FILE: rtl/rau_ctrl.sv
`timescale 1ns / 1ps
module rau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rau_pkg::sts_t  sts,
	output rau_pkg::cmd_t  cmd,
	output logic [1:0]     mul_sel
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_FORM,
		S_ZCHK,
		S_GCD,
		S_DINIT_N,
		S_DSTEP_N,
		S_DINIT_D,
		S_DSTEP_D,
		S_FIN
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;

	assign busy    = (state_q != S_IDLE);
	assign mul_sel = cnt_q[1:0];

	always_comb begin
		cmd          = '0;
		cmd.res_kind = rau_pkg::RK_ZERO;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_CHECK: begin
				if (sts.bad_mode) begin
					cmd.emit = 1'b1;
				end else if (sts.den_zero || sts.div_zero) begin
					cmd.emit     = 1'b1;
					cmd.res_kind = rau_pkg::RK_DIVZERO;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
			end
			S_FORM: begin
				if (sts.is_cmp) begin
					cmd.emit     = 1'b1;
					cmd.res_kind = rau_pkg::RK_CMP;
				end else begin
					cmd.form = 1'b1;
				end
			end
			S_ZCHK: begin
				cmd.emit = sts.num_zero;
			end
			S_GCD: begin
				cmd.gcd_step = 1'b1;
			end
			S_DINIT_N: begin
				cmd.div_init = 1'b1;
			end
			S_DSTEP_N, S_DSTEP_D: begin
				cmd.div_step = 1'b1;
			end
			S_DINIT_D: begin
				cmd.div_init = 1'b1;
				cmd.div_sel  = 1'b1;
			end
			S_FIN: begin
				cmd.emit     = 1'b1;
				cmd.res_kind = rau_pkg::RK_FINAL;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CHECK;
				end
				S_CHECK: begin
					cnt_q <= '0;
					if (sts.bad_mode || sts.den_zero || sts.div_zero) state_q <= S_IDLE;
					else state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) state_q <= S_FORM;
				end
				S_FORM: begin
					state_q <= sts.is_cmp ? S_IDLE : S_ZCHK;
				end
				S_ZCHK: begin
					state_q <= sts.num_zero ? S_IDLE : S_GCD;
				end
				S_GCD: begin
					if (sts.gcd_done) state_q <= S_DINIT_N;
				end
				S_DINIT_N: begin
					cnt_q   <= '0;
					state_q <= S_DSTEP_N;
				end
				S_DSTEP_N: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_DINIT_D;
				end
				S_DINIT_D: begin
					cnt_q   <= '0;
					state_q <= S_DSTEP_D;
				end
				S_DSTEP_D: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/rau_dp.sv
`timescale 1ns / 1ps
module rau_dp #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rau_pkg::item_t   item,
	input  rau_pkg::cmd_t    cmd,
	input  logic [1:0]       mul_sel,
	output rau_pkg::sts_t    sts,
	output rau_pkg::result_t result,
	output logic             done
);

	localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

	rau_pkg::item_t     in_q;
	logic signed [63:0] p_q [4];
	logic               neg_q;
	logic [63:0]        mn_q, md_q, x_q, y_q, g_q, rem_q, dvd_q, qn_q;
	logic [5:0]         k_q;
	rau_pkg::result_t   res_q;
	logic               done_q;

	logic signed [32:0] a_op, b_op;
	logic signed [65:0] prod;
	logic signed [63:0] n_w, d_w;
	logic [64:0]        shl_w, trial_w;
	logic               ovf_w;
	logic [63:0]        qd_w;
	rau_pkg::result_t   res_w;

	always_comb begin
		case (mul_sel)
			2'd0: begin
				a_op = 33'(in_q.a_num);
				b_op = $signed({2'b00, in_q.b_den});
			end
			2'd1: begin
				a_op = $signed({2'b00, in_q.a_den});
				b_op = 33'(in_q.b_num);
			end
			2'd2: begin
				a_op = $signed({2'b00, in_q.a_den});
				b_op = $signed({2'b00, in_q.b_den});
			end
			default: begin
				a_op = 33'(in_q.a_num);
				b_op = 33'(in_q.b_num);
			end
		endcase
		prod = a_op * b_op;
	end

	always_comb begin
		case (in_q.mode)
			rau_pkg::MODE_ADD: n_w = p_q[0] + p_q[1];
			rau_pkg::MODE_SUB: n_w = p_q[0] - p_q[1];
			rau_pkg::MODE_MUL: n_w = p_q[3];
			default:           n_w = p_q[0];
		endcase
		d_w = (in_q.mode == rau_pkg::MODE_DIV) ? p_q[1] : p_q[2];
	end

	assign shl_w   = {rem_q, dvd_q[63]};
	assign trial_w = shl_w - {1'b0, g_q};
	assign qd_w    = dvd_q;
	assign ovf_w   = (qd_w > LIM - 64'd1) || (neg_q ? (qn_q > LIM) : (qn_q > LIM - 64'd1));

	assign sts.bad_mode = (in_q.mode > rau_pkg::MODE_CMP);
	assign sts.den_zero = (in_q.a_den == '0) || (in_q.b_den == '0);
	assign sts.div_zero = (in_q.mode == rau_pkg::MODE_DIV) && (in_q.b_num == '0);
	assign sts.is_cmp   = (in_q.mode == rau_pkg::MODE_CMP);
	assign sts.num_zero = (mn_q == '0);
	assign sts.gcd_done = (x_q == y_q);

	always_comb begin
		res_w         = '0;
		res_w.res_den = 31'd1;
		res_w.status  = rau_pkg::ST_OK;
		case (cmd.res_kind)
			rau_pkg::RK_DIVZERO: res_w.status = rau_pkg::ST_DIVZERO;
			rau_pkg::RK_CMP:     res_w.is_equal = (p_q[0] == p_q[1]);
			rau_pkg::RK_FINAL: begin
				if (ovf_w) begin
					res_w.status = rau_pkg::ST_OVERFLOW;
				end else begin
					res_w.res_num = neg_q ? -qn_q[31:0] : qn_q[31:0];
					res_w.res_den = qd_w[30:0];
				end
			end
			default: res_w.status = rau_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= item;
		if (cmd.mul_en) p_q[mul_sel] <= prod[63:0];
		if (cmd.form) begin
			neg_q <= n_w[63] ^ d_w[63];
			mn_q  <= n_w[63] ? 64'(-n_w) : 64'(n_w);
			md_q  <= d_w[63] ? 64'(-d_w) : 64'(d_w);
			x_q   <= n_w[63] ? 64'(-n_w) : 64'(n_w);
			y_q   <= d_w[63] ? 64'(-d_w) : 64'(d_w);
			k_q   <= '0;
		end
		if (cmd.gcd_step && (x_q != y_q)) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 6'd1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q > y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
		if (cmd.div_init) begin
			g_q   <= x_q << k_q;
			rem_q <= '0;
			dvd_q <= cmd.div_sel ? md_q : mn_q;
			if (cmd.div_sel) qn_q <= dvd_q;
		end
		if (cmd.div_step) begin
			rem_q <= trial_w[64] ? shl_w[63:0] : trial_w[63:0];
			dvd_q <= {dvd_q[62:0], ~trial_w[64]};
		end
		if (cmd.emit) res_q <= res_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.emit;
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

FILE: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Exact fraction add, subtract, multiply, divide and compare with gcd reduction.
// One item at a time: start is taken while busy is low, and the result shows on
// result for the single cycle in which done is high; the receiver cannot stall it.
// An invalid mode, zero denominator or zero divisor is answered from the check
// state; compare answers once all four products are formed, and a zero numerator
// after the form step. Otherwise the shared 33x33 multiplier forms four products,
// the binary gcd takes one step per cycle, and the 1-bit-per-cycle divider works
// out each of the two quotients in turn.
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rau_pkg::item_t   item,
	output rau_pkg::result_t result,
	output logic             done
);

	rau_pkg::cmd_t cmd;
	rau_pkg::sts_t sts;
	logic [1:0]    mul_sel;

	rau_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sts     (sts),
		.cmd     (cmd),
		.mul_sel (mul_sel)
	);

	rau_dp #(.WIDTH(WIDTH)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.mul_sel (mul_sel),
		.sts     (sts),
		.result  (result),
		.done    (done)
	);

endmodule

FILE: rtl/rau_chk.sv
`timescale 1ns / 1ps
module rau_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input rau_pkg::result_t result,
	input logic             done
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted start");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.res_den != '0)
		else $error("zero result denominator");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != rau_pkg::ST_OK |->
		result.res_num == '0 && result.res_den == 31'd1 && !result.is_equal)
		else $error("error result not 0/1");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status != 2'd3)
		else $error("undefined status code");

endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.result (result),
	.done   (done)
);
